FILE: rtl/mac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and codes for the mask driven ARGB compositor.
// ----------------------------------------------------------------------------
package mac_pkg;

  localparam int unsigned PIX_W = 32;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned IDX_W = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_PAINT_COLOR  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MASK_CHANNEL = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BLEND_MODE   = 2'd2;

  localparam logic [CH_W-1:0] CH_MAX = 8'hff;

  typedef enum logic [1:0] {
    MASK_RED,
    MASK_GREEN,
    MASK_BLUE,
    MASK_NONE
  } mask_sel_t;

  typedef enum logic [1:0] {
    MODE_COLOR,
    MODE_SHADOW,
    MODE_IMAGE_KEEP,
    MODE_IMAGE_OPAQUE
  } blend_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] paint_color;
    mask_sel_t        mask_channel;
    blend_mode_t      blend_mode;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] canvas_pixel;
    logic [PIX_W-1:0] mask_pixel;
    logic [PIX_W-1:0] image_pixel;
    logic             inside_mask;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             was_written;
  } pix_out_t;

  // (src*a + dst*(255-a)) >> 8, sum stays below 2^16
  function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] src,
                                                  input logic [CH_W-1:0] dst,
                                                  input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] p_src;
    logic [2*CH_W-1:0] p_dst;
    logic [2*CH_W:0]   sum;
    p_src = {{CH_W{1'b0}}, src} * {{CH_W{1'b0}}, a};
    p_dst = {{CH_W{1'b0}}, dst} * {{CH_W{1'b0}}, CH_MAX - a};
    sum   = {1'b0, p_src} + {1'b0, p_dst};
    return sum[2*CH_W-1:CH_W];
  endfunction

  // floor(x / 255) for x up to 255*255
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] t;
    t = {1'b0, x} + {{(2*CH_W){1'b0}}, 1'b1} + {{(CH_W+1){1'b0}}, x[2*CH_W-1:CH_W]};
    return t[2*CH_W-1:CH_W];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mac_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_blend
// Combinational pixel compositor: channel gate, weight select and
// per-channel blend of one registered pixel set.
// ----------------------------------------------------------------------------
module mac_blend (
  input  wire mac_pkg::cfg_t    cfg,
  input  wire mac_pkg::pix_in_t pix_in,
  output mac_pkg::pix_out_t     pix_out
);

  logic [mac_pkg::CH_W-1:0]   gate;
  logic [mac_pkg::CH_W-1:0]   mask_a;
  logic [mac_pkg::CH_W-1:0]   weight;
  logic [mac_pkg::CH_W-1:0]   alpha_out;
  logic [mac_pkg::CH_W-1:0]   shadow_a;
  logic [2*mac_pkg::CH_W-1:0] shadow_p;
  logic [mac_pkg::PIX_W-1:0]  src;
  logic [mac_pkg::PIX_W-1:0]  dst;
  logic [mac_pkg::CH_W-1:0]   r_mix;
  logic [mac_pkg::CH_W-1:0]   g_mix;
  logic [mac_pkg::CH_W-1:0]   b_mix;
  logic                       hit;

  assign mask_a = pix_in.mask_pixel[31:24];
  assign dst    = pix_in.canvas_pixel;

  always_comb begin
    unique case (cfg.mask_channel)
      mac_pkg::MASK_RED:   gate = pix_in.mask_pixel[23:16];
      mac_pkg::MASK_GREEN: gate = pix_in.mask_pixel[15:8];
      mac_pkg::MASK_BLUE:  gate = pix_in.mask_pixel[7:0];
      default:             gate = '0;
    endcase
  end

  // shadow alpha is mask alpha scaled by paint alpha
  assign shadow_p = {{mac_pkg::CH_W{1'b0}}, mask_a} *
                    {{mac_pkg::CH_W{1'b0}}, cfg.paint_color[31:24]};
  assign shadow_a = mac_pkg::div255(shadow_p);

  always_comb begin
    unique case (cfg.blend_mode)
      mac_pkg::MODE_COLOR: begin
        src       = cfg.paint_color;
        weight    = gate;
        alpha_out = gate;
      end
      mac_pkg::MODE_SHADOW: begin
        src       = cfg.paint_color;
        weight    = mask_a;
        alpha_out = shadow_a;
      end
      mac_pkg::MODE_IMAGE_KEEP: begin
        src       = pix_in.image_pixel;
        weight    = mask_a;
        alpha_out = mask_a;
      end
      default: begin
        src       = pix_in.image_pixel;
        weight    = mask_a;
        alpha_out = mac_pkg::CH_MAX;
      end
    endcase
  end

  assign r_mix = mac_pkg::mix_channel(src[23:16], dst[23:16], weight);
  assign g_mix = mac_pkg::mix_channel(src[15:8],  dst[15:8],  weight);
  assign b_mix = mac_pkg::mix_channel(src[7:0],   dst[7:0],   weight);

  assign hit = pix_in.inside_mask && (gate != '0);

  always_comb begin
    pix_out.was_written = hit;
    pix_out.pixel       = hit ? {alpha_out, r_mix, g_mix, b_mix} : dst;
  end

endmodule
`default_nettype wire

FILE: rtl/mask_alpha_compositor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mask_alpha_compositor
// Mask gated ARGB8888 compositor, one pixel per clock while out_stall is low.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  canvas, mask, image pixel, inside flag
//   out_*       out  out_valid/out_stall out pixel, was_written
//   cfg_*       in   cfg_we             cfg_index, cfg_data
//
// one pixel accepted per cycle while out_stall is low; each result passes
// through the input register, blend logic and result register
// synchronous active-low reset clears valids and all config registers
// out_stall backs up through the input register into in_stall in the same cycle
// ----------------------------------------------------------------------------
module mask_alpha_compositor (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [mac_pkg::IDX_W-1:0]     cfg_index,
  input  wire [mac_pkg::CFG_W-1:0]     cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [mac_pkg::PIX_W-1:0]     in_canvas_pixel,
  input  wire [mac_pkg::PIX_W-1:0]     in_mask_pixel,
  input  wire [mac_pkg::PIX_W-1:0]     in_image_pixel,
  input  wire                          in_inside_mask,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [mac_pkg::PIX_W-1:0]    out_pixel,
  output logic                         out_was_written
);

  mac_pkg::cfg_t     cfg_r;
  mac_pkg::cfg_t     cfg_nxt;
  mac_pkg::pix_in_t  s1_r;
  mac_pkg::pix_out_t blend_out;
  mac_pkg::pix_out_t res_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              res_load;
  logic              s1_load;

  // config writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mac_pkg::CFG_PAINT_COLOR:  cfg_nxt.paint_color  = cfg_data;
        mac_pkg::CFG_MASK_CHANNEL: cfg_nxt.mask_channel = mac_pkg::mask_sel_t'(cfg_data[1:0]);
        mac_pkg::CFG_BLEND_MODE:   cfg_nxt.blend_mode   = mac_pkg::blend_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paint_color  <= '0;
      cfg_r.mask_channel <= mac_pkg::MASK_RED;
      cfg_r.blend_mode   <= mac_pkg::MODE_COLOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // result register frees when empty or taken
  assign res_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || res_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (res_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_r.canvas_pixel <= in_canvas_pixel;
      s1_r.mask_pixel   <= in_mask_pixel;
      s1_r.image_pixel  <= in_image_pixel;
      s1_r.inside_mask  <= in_inside_mask;
    end
    if (res_load && s1_valid_r) begin
      res_r <= blend_out;
    end
  end

  mac_blend u_blend (
    .cfg     (cfg_r),
    .pix_in  (s1_r),
    .pix_out (blend_out)
  );

  assign out_valid       = out_valid_r;
  assign out_pixel       = res_r.pixel;
  assign out_was_written = res_r.was_written;

`ifndef ASSERT_OFF
  // an item outside the mask leaves the canvas pixel as it was
  a_outside_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res_load && !s1_r.inside_mask)
      |=> (out_pixel == $past(s1_r.canvas_pixel)) && !out_was_written)
    else $error("pixel outside mask was modified");

  // a held item in the input register is not dropped
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !res_load) |=> s1_valid_r)
    else $error("input register lost a pending beat");

  // with an empty input register the block never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall asserted with empty input register");

  // no result appears when the result register loads from an empty input register
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && res_load) |=> !out_valid)
    else $error("result appeared without an item in flight");
`endif

endmodule
`default_nettype wire
